>>> rtl/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg: shared types, constants and helpers for the Targa RLE encoder
// Sizes, register codes, the controller/datapath command and status
// structs, and the pixel packing functions.
// ----------------------------------------------------------------------------
package tre_pkg;

   // Longest packet, in pixels, and the literal run store behind it.
   localparam int RUN_MAX     = 128;
   localparam int STORE_DEPTH = 128;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int RUN_W       = $clog2(RUN_MAX + 1);

   // Result words per input before the rest is carried to the next input.
   localparam int WORD_LIMIT  = 64;
   localparam int WORDS_W     = $clog2(WORD_LIMIT + 1);

   localparam int PIX_W       = 32;
   localparam int ACC_W       = 64;
   localparam int CNT_W       = 4;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 72;
   localparam int CSR_DATA_W  = 16;

   // Config register indexes.
   localparam logic CSR_PIXEL_BYTES = 1'b0;
   localparam logic CSR_LINE_WIDTH  = 1'b1;

   localparam logic [2:0]  PIXEL_BYTES_RST = 3'd3;
   localparam logic [15:0] LINE_WIDTH_RST  = 16'd640;

   // Run bookkeeping operations applied by the datapath.
   typedef enum logic [2:0] {
      RUN_HOLD,
      RUN_NEW_COPY,   // fresh literal run of one pixel, store[0] written
      RUN_REP2_NEW,   // repeat of two, store[0] written
      RUN_REP2_KEEP,  // repeat of two, store[0] kept
      RUN_APPEND,     // add pixel to literal run
      RUN_REP_INC,    // extend repeat run
      RUN_CLEAR       // drop both runs
   } run_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LOAD,
      ST_EMIT_HDR,
      ST_EMIT_PIX,
      ST_POST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       col_step;
      run_op_type run_op;
      logic       job_load;
      logic       job_trim;
      logic       push_hdr;
      logic       push_pix;
      logic       flush_word;
   } tre_cmd_type;

   typedef struct packed {
      logic op_flush;
      logic at_line_end;
      logic copy_zero;
      logic copy_one;
      logic copy_many;
      logic rep_zero;
      logic same_first;
      logic same_last;
      logic copy_at_max;
      logic rep_at_max;
      logic pix_last;
      logic out_free;
      logic acc_pending;
   } tre_status_type;

   // Unused size codes fold onto the nearest legal one.
   function automatic logic [2:0] pixel_size(input logic [2:0] pb);
      logic [2:0] s;
      if (pb == 3'd0)
         s = 3'd1;
      else if (pb > 3'd4)
         s = 3'd4;
      else
         s = pb;
      return s;
   endfunction

   function automatic logic [PIX_W-1:0] size_mask(input logic [2:0] size);
      logic [PIX_W-1:0] m;
      case (size)
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   // Byte 0 of the result leaves first.
   function automatic logic [PIX_W-1:0] pack_pixel(input logic [2:0] size,
                                                   input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b,
                                                   input logic [7:0] a);
      logic [7:0]       hi;
      logic [7:0]       lo;
      logic [PIX_W-1:0] res;
      // 5-5-5: attribute bit, R5, G5 top two bits | G5 low three bits, B5
      hi = {(a != 8'hFF), r[7:3], g[7:6]};
      lo = {g[5:3], b[7:3]};
      case (size)
         3'd1:    res = {24'd0, r};
         3'd2:    res = {16'd0, hi, lo};
         3'd3:    res = {8'd0, r, g, b};
         default: res = {a, r, g, b};
      endcase
      return res;
   endfunction

endpackage

>>> rtl/tre_ram.sv
// ----------------------------------------------------------------------------
// tre_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module tre_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 128,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tre_datapath.sv
// ----------------------------------------------------------------------------
// tre_datapath: run state, pixel store, byte packer and result register
// Executes controller commands; reports run and output status back.
// ----------------------------------------------------------------------------
module tre_datapath import tre_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  tre_cmd_type           cmd,
   output tre_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // config
   logic [2:0]            pixel_bytes_ff, pixel_bytes_in;
   logic [15:0]           line_width_ff, line_width_in;
   // current input
   logic                  op_ff, op_in;
   logic [PIX_W-1:0]      pix_ff, pix_in;
   // run state
   logic [PIX_W-1:0]      first_ff, first_in;
   logic [PIX_W-1:0]      last_ff, last_in;
   logic [RUN_W-1:0]      copy_ff, copy_in;
   logic [RUN_W-1:0]      rep_ff, rep_in;
   logic [15:0]           col_ff, col_in;
   // packet job
   logic [RUN_W-1:0]      emit_n_ff, emit_n_in;
   logic                  emit_rep_ff, emit_rep_in;
   logic [STORE_AW-1:0]   emit_idx_ff, emit_idx_in;
   // byte packer
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      acc_cnt_ff, acc_cnt_in;
   logic [WORDS_W-1:0]    words_ff, words_in;
   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]      rsp_bytes_ff, rsp_bytes_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [2:0]            size;
   logic [PIX_W-1:0]      mask;
   logic [RUN_W-1:0]      hdr_cnt;
   logic [PIX_W-1:0]      push_data;
   logic [CNT_W-1:0]      push_len;
   logic [CNT_W-1:0]      total;
   logic [6:0]            shift;
   logic [ACC_W+PIX_W-1:0] win;
   logic                  push;
   logic                  overflow;
   logic                  out_free;
   logic                  ram_we;
   logic [STORE_AW-1:0]   ram_waddr;
   logic [STORE_AW-1:0]   ram_raddr;
   logic [PIX_W-1:0]      ram_rd;

   assign size     = pixel_size(pixel_bytes_ff);
   assign mask     = size_mask(size);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---- packer: header or pixel bytes appended above the pending bytes
   assign hdr_cnt = emit_n_ff - 1'b1;
   assign push    = cmd.push_hdr || cmd.push_pix;

   always_comb begin
      if (cmd.push_hdr) begin
         push_data = {24'd0, emit_rep_ff, hdr_cnt[6:0]};
         push_len  = CNT_W'(1);
      end else begin
         push_data = (emit_rep_ff ? first_ff : ram_rd) & mask;
         push_len  = CNT_W'(size);
      end
   end

   assign shift    = {acc_cnt_ff, 3'b000};
   assign win      = {{PIX_W{1'b0}}, acc_ff} | ({{ACC_W{1'b0}}, push_data} << shift);
   assign total    = acc_cnt_ff + push_len;
   assign overflow = push && (total > CNT_W'(8));

   // ---- store port
   assign ram_we    = (cmd.run_op == RUN_NEW_COPY) || (cmd.run_op == RUN_REP2_NEW) ||
                      (cmd.run_op == RUN_APPEND);
   assign ram_waddr = (cmd.run_op == RUN_APPEND) ? copy_ff[STORE_AW-1:0] : '0;
   assign ram_raddr = cmd.push_hdr ? '0 : emit_idx_ff + 1'b1;

   tre_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (pix_ff),
      .rd_en   (push),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd)
   );

   // ---- next state
   always_comb begin
      pixel_bytes_in = pixel_bytes_ff;
      line_width_in  = line_width_ff;
      op_in          = op_ff;
      pix_in         = pix_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      copy_in        = copy_ff;
      rep_in         = rep_ff;
      col_in         = col_ff;
      emit_n_in      = emit_n_ff;
      emit_rep_in    = emit_rep_ff;
      emit_idx_in    = emit_idx_ff;
      acc_in         = acc_ff;
      acc_cnt_in     = acc_cnt_ff;
      words_in       = words_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_PIXEL_BYTES: pixel_bytes_in = csr_wdata[2:0];
            CSR_LINE_WIDTH:  line_width_in  = csr_wdata;
            default:         ;
         endcase
      end

      if (cmd.capture) begin
         op_in    = req_tuser;
         pix_in   = pack_pixel(size, req_tdata[7:0], req_tdata[15:8],
                               req_tdata[23:16], req_tdata[31:24]);
         words_in = '0;
      end

      // line boundary restarts the column at the new pixel
      if (cmd.col_step) begin
         col_in = (col_ff == line_width_ff) ? 16'd1 : col_ff + 16'd1;
      end

      case (cmd.run_op)
         RUN_NEW_COPY: begin
            copy_in  = RUN_W'(1);
            rep_in   = '0;
            first_in = pix_ff;
            last_in  = pix_ff;
         end
         RUN_REP2_NEW: begin
            copy_in  = '0;
            rep_in   = RUN_W'(2);
            first_in = pix_ff;
         end
         RUN_REP2_KEEP: begin
            copy_in = '0;
            rep_in  = RUN_W'(2);
         end
         RUN_APPEND: begin
            copy_in = copy_ff + 1'b1;
            last_in = pix_ff;
         end
         RUN_REP_INC: rep_in = rep_ff + 1'b1;
         RUN_CLEAR: begin
            copy_in = '0;
            rep_in  = '0;
         end
         default: ;
      endcase

      // literal job takes the run, less its last pixel when that one
      // turns into the head of a repeat
      if (cmd.job_load) begin
         if (copy_ff != '0) begin
            emit_n_in   = copy_ff - RUN_W'(cmd.job_trim);
            emit_rep_in = 1'b0;
         end else begin
            emit_n_in   = rep_ff;
            emit_rep_in = 1'b1;
         end
      end

      if (cmd.push_hdr)
         emit_idx_in = '0;
      else if (cmd.push_pix)
         emit_idx_in = emit_idx_ff + 1'b1;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      if (cmd.flush_word) begin
         rsp_valid_in = 1'b1;
         rsp_bytes_in = acc_ff;
         rsp_cnt_in   = acc_cnt_ff;
         rsp_last_in  = 1'b1;
         acc_in       = '0;
         acc_cnt_in   = '0;
         words_in     = words_ff + 1'b1;
      end else if (overflow) begin
         // full word leaves; final one of the input if at the word limit
         rsp_valid_in = 1'b1;
         rsp_bytes_in = win[ACC_W-1:0];
         rsp_cnt_in   = CNT_W'(8);
         rsp_last_in  = (words_ff == WORDS_W'(WORD_LIMIT - 1));
         acc_in       = win[ACC_W+PIX_W-1:ACC_W];
         acc_cnt_in   = total - CNT_W'(8);
         words_in     = words_ff + 1'b1;
      end else if (push) begin
         acc_in     = win[ACC_W-1:0];
         acc_cnt_in = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= PIXEL_BYTES_RST;
         line_width_ff  <= LINE_WIDTH_RST;
         copy_ff        <= '0;
         rep_ff         <= '0;
         col_ff         <= '0;
         acc_ff         <= '0;
         acc_cnt_ff     <= '0;
         words_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pixel_bytes_ff <= pixel_bytes_in;
         line_width_ff  <= line_width_in;
         copy_ff        <= copy_in;
         rep_ff         <= rep_in;
         col_ff         <= col_in;
         acc_ff         <= acc_in;
         acc_cnt_ff     <= acc_cnt_in;
         words_ff       <= words_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pix_ff       <= pix_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      emit_n_ff    <= emit_n_in;
      emit_rep_ff  <= emit_rep_in;
      emit_idx_ff  <= emit_idx_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---- status
   always_comb begin
      status.op_flush    = op_ff;
      status.at_line_end = (col_ff == line_width_ff);
      status.copy_zero   = (copy_ff == '0);
      status.copy_one    = (copy_ff == RUN_W'(1));
      status.copy_many   = (copy_ff > RUN_W'(1));
      status.rep_zero    = (rep_ff == '0);
      status.same_first  = (((first_ff ^ pix_ff) & mask) == '0);
      status.same_last   = (((last_ff ^ pix_ff) & mask) == '0);
      status.copy_at_max = (({1'b0, copy_ff} + 1'b1) >= (RUN_W + 1)'(RUN_MAX));
      status.rep_at_max  = (({1'b0, rep_ff} + 1'b1) >= (RUN_W + 1)'(RUN_MAX));
      status.pix_last    = emit_rep_ff || (RUN_W'(emit_idx_ff) == hdr_cnt);
      status.out_free    = out_free;
      status.acc_pending = (acc_cnt_ff != '0) && (words_ff < WORDS_W'(WORD_LIMIT));
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ACC_W - CNT_W){1'b0}}, rsp_cnt_ff, rsp_bytes_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---- checks
   a_acc_cnt_range: assert property (@(posedge clock) disable iff (reset)
      acc_cnt_ff <= CNT_W'(8))
      else $error("packer holds more than one word");

   a_one_run_kind: assert property (@(posedge clock) disable iff (reset)
      !((copy_ff != '0) && (rep_ff != '0)))
      else $error("literal and repeat run both open");

   a_short_word_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_cnt_ff == CNT_W'(8)))
      else $error("partial word not marked final");

   a_word_limit: assert property (@(posedge clock) disable iff (reset)
      words_ff <= WORDS_W'(WORD_LIMIT))
      else $error("too many words for one input");

endmodule

>>> rtl/tre_ctrl.sv
// ----------------------------------------------------------------------------
// tre_ctrl: encoder sequencer
// Classifies each input against the open run, then steps packet emission.
// ----------------------------------------------------------------------------
module tre_ctrl import tre_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  tre_status_type status,
   output tre_cmd_type    cmd
);

   state_type  state_ff, state_in;
   run_op_type post_ff, post_in;
   logic       trim_ff, trim_in;
   state_type  done_state;

   assign done_state = status.acc_pending ? ST_FINISH : ST_IDLE;

   always_comb begin
      state_in   = state_ff;
      post_in    = post_ff;
      trim_in    = trim_ff;
      cmd        = '0;
      cmd.run_op = RUN_HOLD;
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            trim_in = 1'b0;
            post_in = RUN_CLEAR;
            if (status.op_flush) begin
               state_in = ST_LOAD;
            end else begin
               cmd.col_step = 1'b1;
               if (status.at_line_end) begin
                  // close the line first, pixel opens a new run
                  post_in  = RUN_NEW_COPY;
                  state_in = ST_LOAD;
               end else if (status.copy_zero && status.rep_zero) begin
                  cmd.run_op = RUN_NEW_COPY;
                  state_in   = done_state;
               end else if (status.copy_one && status.same_first) begin
                  cmd.run_op = RUN_REP2_KEEP;
                  state_in   = (RUN_MAX <= 2) ? ST_LOAD : done_state;
               end else if (status.copy_many && status.same_last) begin
                  // literal run minus its tail, tail plus pixel become a repeat
                  trim_in  = 1'b1;
                  post_in  = RUN_REP2_NEW;
                  state_in = ST_LOAD;
               end else if (!status.copy_zero) begin
                  cmd.run_op = RUN_APPEND;
                  state_in   = status.copy_at_max ? ST_LOAD : done_state;
               end else if (status.same_first) begin
                  cmd.run_op = RUN_REP_INC;
                  state_in   = status.rep_at_max ? ST_LOAD : done_state;
               end else begin
                  post_in  = RUN_NEW_COPY;
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            if (status.copy_zero && status.rep_zero) begin
               state_in = ST_POST;
            end else begin
               cmd.job_load = 1'b1;
               cmd.job_trim = trim_ff;
               state_in     = ST_EMIT_HDR;
            end
         end

         ST_EMIT_HDR: begin
            if (status.out_free) begin
               cmd.push_hdr = 1'b1;
               state_in     = ST_EMIT_PIX;
            end
         end

         ST_EMIT_PIX: begin
            if (status.out_free) begin
               cmd.push_pix = 1'b1;
               if (status.pix_last)
                  state_in = ST_POST;
            end
         end

         ST_POST: begin
            cmd.run_op = post_ff;
            state_in   = ST_FINISH;
         end

         ST_FINISH: begin
            if (!status.acc_pending) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush_word = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         post_ff  <= RUN_CLEAR;
         trim_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
         trim_ff  <= trim_in;
      end
   end

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_hdr || cmd.push_pix || cmd.flush_word) |-> status.out_free)
      else $error("byte push while result register blocked");

   a_header_then_pixel: assert property (@(posedge clock) disable iff (reset)
      cmd.push_hdr |=> (state_ff == ST_EMIT_PIX))
      else $error("header not followed by pixel phase");

endmodule

>>> rtl/targa_rle_pixel_encoder.sv
// ----------------------------------------------------------------------------
// targa_rle_pixel_encoder: Targa run-length packet encoder
// RGBA pixels in, RLE packet byte stream out, eight bytes to a word.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake               payload
//  req_     in   req_tvalid/req_tready   tdata: red, green, blue, alpha
//                                        tuser: operation (1 = flush)
//  rsp_     out  rsp_tvalid/rsp_tready   tdata: out_bytes, byte_count
//                                        tlast: final word of the input
//  csr_     in   csr_we (no wait)        csr_index, csr_wdata
//
//  Steps: a pixel that closes no packet is accepted and classified; a
//    carried partial word then leaves, if there is one. An input that
//    closes a literal packet of n pixels goes through accept, classify,
//    load, header, one pixel-store read per pixel, run update and final
//    word; a repeat packet sends its pixel once.
//  Reset is synchronous: runs, column, partial word and result register
//    clear. The pixel store is not cleared; only entries written earlier
//    in the open run are read.
//  rsp_tready low freezes packet emission; the next word is taken only
//    once the current input has finished.
//
// ----------------------------------------------------------------------------
module targa_rle_pixel_encoder import tre_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // pixel words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input  logic                  req_tuser,  // operation
   // byte stream words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_bytes[63:0], byte_count[67:64], zero pad
   output logic                  rsp_tlast,
   // config writes
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tre_cmd_type    cmd;
   tre_status_type status;

   // sequencer: classifies the input, walks header and pixels of a packet
   tre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // run state, pixel store, byte packer, result register
   tre_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/tre_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tre_tb_pkg: codes shared by the encoder testbench files
// Operation codes carried on req_tuser.
// ----------------------------------------------------------------------------
package tre_tb_pkg;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } tre_op_type;

endpackage

>>> verif/tre_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tre_stream_checker: predicts and checks the encoder's byte stream words
// Watches config writes and accepted pixel words, runs a packet encoder of
// its own to build the expected stream words, and compares each accepted
// result word field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module tre_stream_checker
   import tre_pkg::*;
   import tre_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // red, green, blue, alpha
   input  logic                  req_tuser,  // operation
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // out_bytes, byte_count, pad
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    words_due
);

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic        last;
   } stream_word_type;

   localparam int BYTES_PER_STEP = WORD_LIMIT * 8;
   localparam int REPORT_LIMIT   = 10;

   logic [2:0]      pixel_bytes_q;
   logic [15:0]     line_width_q;
   logic [31:0]     run_store [STORE_DEPTH];
   int              copy_len;
   int              repeat_len;
   logic [15:0]     column;
   logic [7:0]      byte_carry [$];
   stream_word_type expected_words [$];
   int              failures;

   // codes 0 and 5..7 fold onto the nearest legal size
   function automatic logic [2:0] eff_size();
      case (pixel_bytes_q)
         3'd0:                   return 3'd1;
         3'd1, 3'd2, 3'd3, 3'd4: return pixel_bytes_q;
         default:                return 3'd4;
      endcase
   endfunction

   function automatic logic [31:0] pack_rgba(input logic [2:0] sz, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b,
                                             input logic [7:0] a);
      logic [15:0] rgb555;
      rgb555 = {a != 8'hFF, r[7:3], g[7:3], b[7:3]};
      case (sz)
         3'd1:    return {24'd0, r};
         3'd2:    return {16'd0, rgb555};
         3'd3:    return {8'd0, r, g, b};
         default: return {a, r, g, b};
      endcase
   endfunction

   function automatic bit pixels_match(input logic [31:0] x, input logic [31:0] y,
                                       input logic [2:0] sz);
      int j;
      for (j = 0; j < sz; j++)
         if (x[8*j +: 8] != y[8*j +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void push_pixel(input logic [31:0] w, input logic [2:0] sz);
      int j;
      for (j = 0; j < sz; j++) byte_carry.push_back(w[8*j +: 8]);
   endfunction

   function automatic void emit_literal(input int n, input logic [2:0] sz);
      int i;
      byte_carry.push_back({1'b0, 7'(n - 1)});
      for (i = 0; i < n; i++) push_pixel(run_store[i % STORE_DEPTH], sz);
   endfunction

   function automatic void emit_run_packet(input int n, input logic [2:0] sz);
      byte_carry.push_back({1'b1, 7'(n - 1)});
      push_pixel(run_store[0], sz);
   endfunction

   function automatic void close_run(input logic [2:0] sz);
      if (copy_len > 0)
         emit_literal(copy_len, sz);
      else if (repeat_len > 0)
         emit_run_packet(repeat_len, sz);
      copy_len   = 0;
      repeat_len = 0;
   endfunction

   function automatic void begin_repeat(input logic [2:0] sz);
      copy_len   = 0;
      repeat_len = 2;
      if (repeat_len >= RUN_MAX) close_run(sz);
   endfunction

   function automatic void encode_pixel(input logic [31:0] w, input logic [2:0] sz);
      if (column == line_width_q) begin
         close_run(sz);
         column = '0;
      end
      column = column + 16'd1;
      if (copy_len == 0 && repeat_len == 0) begin
         copy_len     = 1;
         run_store[0] = w;
      end else if (copy_len == 1 && pixels_match(run_store[0], w, sz)) begin
         begin_repeat(sz);
      end else if (copy_len > 1 &&
                   pixels_match(run_store[(copy_len - 1) % STORE_DEPTH], w, sz)) begin
         // literal meets a copy of its last pixel: that pixel moves to a repeat
         emit_literal(copy_len - 1, sz);
         run_store[0] = w;
         begin_repeat(sz);
      end else if (copy_len > 0) begin
         run_store[copy_len % STORE_DEPTH] = w;
         copy_len++;
         if (copy_len >= RUN_MAX) close_run(sz);
      end else if (pixels_match(run_store[0], w, sz)) begin
         repeat_len++;
         if (repeat_len >= RUN_MAX) close_run(sz);
      end else begin
         emit_run_packet(repeat_len, sz);
         run_store[0] = w;
         copy_len     = 1;
         repeat_len   = 0;
      end
   endfunction

   // at most 64 words per input; the rest waits for the next input
   function automatic void release_words();
      int              take;
      int              k;
      int              j;
      int              cnt;
      stream_word_type w;
      take = (byte_carry.size() > BYTES_PER_STEP) ? BYTES_PER_STEP : byte_carry.size();
      for (k = 0; k < take; k += 8) begin
         cnt = (take - k > 8) ? 8 : take - k;
         w   = '0;
         for (j = 0; j < cnt; j++) w.out_bytes[8*j +: 8] = byte_carry.pop_front();
         w.byte_count = 4'(cnt);
         w.last       = (k + 8 >= take);
         expected_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : watch
      stream_word_type got;
      stream_word_type want;
      logic [2:0]      sz;
      if (reset) begin
         pixel_bytes_q = PIXEL_BYTES_RST;
         line_width_q  = LINE_WIDTH_RST;
         copy_len      = 0;
         repeat_len    = 0;
         column        = '0;
         failures      = 0;
         byte_carry.delete();
         expected_words.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PIXEL_BYTES)
               pixel_bytes_q = csr_wdata[2:0];
            else
               line_width_q = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            sz = eff_size();
            if (req_tuser == OP_FLUSH)
               close_run(sz);
            else
               encode_pixel(pack_rgba(sz, req_tdata[7:0], req_tdata[15:8],
                                      req_tdata[23:16], req_tdata[31:24]), sz);
            release_words();
         end
         if (rsp_tvalid && rsp_tready) begin
            got.out_bytes  = rsp_tdata[63:0];
            got.byte_count = rsp_tdata[67:64];
            got.last       = rsp_tlast;
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected word: bytes %h count %0d last %0b",
                           got.out_bytes, got.byte_count, got.last);
            end else begin
               want = expected_words.pop_front();
               if (got.out_bytes != want.out_bytes || got.byte_count != want.byte_count ||
                   got.last != want.last) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"word mismatch: expected bytes %h count %0d last %0b, ",
                               "got bytes %h count %0d last %0b"},
                              want.out_bytes, want.byte_count, want.last,
                              got.out_bytes, got.byte_count, got.last);
               end
            end
         end
      end
      fail_count <= failures;
      words_due  <= expected_words.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Targa RLE pixel encoder
// Drives pixel and flush words through the request stream under several
// pixel sizes and line widths, with random gaps on the sender and random
// stalls on the receiver. The stream checker beside the encoder predicts
// every byte stream word and counts failures; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import tre_pkg::*;
   import tre_tb_pkg::*;

   localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either side
   localparam int SETTLE_CYCLES = 32;    // encoder tail after the last result word
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 9;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_PIXEL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = CSR_PIXEL_BYTES;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int          fail_count;
   int          words_due;
   int          idle_pct     = 0;
   int          stall_pct    = 0;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   // stimulus-side line position, only used to pick line widths that land
   logic [15:0] line_col     = '0;
   logic [15:0] lw_now       = LINE_WIDTH_RST;
   logic [31:0] last_rgba    = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   targa_rle_pixel_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tre_stream_checker u_stream_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   // receiver: one random draw per cycle
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // watchdog: a hang shows up as a long stretch with nothing accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
   task automatic set_idling(input int mode);
      case (mode)
         1:       begin idle_pct = 53; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 53; end
         3:       begin idle_pct = 34; stall_pct = 34; end
         default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // tdata layout: red lowest, alpha highest
   function automatic logic [31:0] rgba(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a);
      return {a, b, g, r};
   endfunction

   // returns at the edge that takes the word; valid stays up for a follow-on word
   task automatic send_word(input tre_op_type op, input logic [31:0] data);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_pixel(input logic [31:0] data);
      if (line_col == lw_now) line_col = '0;
      line_col  = line_col + 16'd1;
      last_rgba = data;
      send_word(OP_PIXEL, data);
   endtask

   // pixel fields are don't-care on a flush, so fill them with noise
   task automatic send_flush();
      send_word(OP_FLUSH, $urandom());
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   // a word that closes no packet may still be in flight after the last result
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers back to back, write enable held across the pair
   task automatic configure(input logic [2:0] pb, input logic [15:0] lw);
      csr_we    <= 1'b1;
      csr_index <= CSR_PIXEL_BYTES;
      csr_wdata <= {13'd0, pb};
      @(posedge clock);
      csr_index <= CSR_LINE_WIDTH;
      csr_wdata <= lw;
      @(posedge clock);
      csr_we    <= 1'b0;
      lw_now = lw;
   endtask

   // mostly well-formed runs with random content, some near-duplicates and noise
   task automatic random_phase(input int target);
      int          first;
      int          pause_at;
      int          kind;
      int          len;
      int          i;
      bit          paused;
      logic [31:0] px;
      logic [31:0] palette [4];
      first    = items_sent;
      pause_at = $urandom_range(target - 1);
      paused   = 1'b0;
      for (i = 0; i < 4; i++) palette[i] = $urandom();
      // differs from entry 0 only in bits the 5-5-5 packing drops
      palette[1] = palette[0] ^ 32'h0007_0707;
      while (items_sent - first < target) begin
         if (!paused && items_sent - first >= pause_at) begin
            // sender holds off until the encoder has drained
            wait_results();
            paused = 1'b1;
         end
         kind = $urandom_range(99);
         if (kind < 40) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(2, 5);
            px  = $urandom();
            repeat (len) send_pixel(px);
         end else if (kind < 70) begin
            len = $urandom_range(1, 6);
            repeat (len) send_pixel($urandom());
         end else if (kind < 80) begin
            px = last_rgba ^ ($urandom() & 32'h0007_0707);
            if ($urandom_range(1) != 0) px[31:24] = 8'($urandom());
            repeat ($urandom_range(1, 3)) send_pixel(px);
         end else if (kind < 88) begin
            send_flush();
         end else begin
            repeat ($urandom_range(1, 3)) send_pixel(palette[$urandom_range(3)]);
         end
      end
   endtask

   initial begin
      int          phase;
      logic [2:0]  pb;
      logic [15:0] lw;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset values (BGR, 640-pixel lines) ---
      send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));  // literal of one, then repeat
      send_flush();
      send_flush();                                  // nothing pending: no word

      // --- 5-5-5 with a line boundary every three pixels ---
      settle();
      configure(3'd2, line_col);
      send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));  // boundary, nothing pending
      send_pixel(rgba(8'hF8, 8'hF8, 8'hF8, 8'hFF));  // same after packing
      send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFE));  // attribute bit breaks repeat
      send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));  // boundary flushes literal
      send_pixel(rgba(8'h07, 8'h07, 8'h07, 8'h80));
      send_pixel(rgba(8'h12, 8'h34, 8'h56, 8'hFF));
      send_flush();
      send_pixel(rgba(8'hAA, 8'h55, 8'hAA, 8'h55));

      // --- one-pixel lines; stored 2-byte pixel leaves at 4 bytes ---
      settle();
      configure(3'd4, 16'd1);
      send_pixel(rgba(8'h01, 8'h02, 8'h03, 8'h04));
      send_pixel(rgba(8'h01, 8'h02, 8'h03, 8'h04));
      send_pixel(rgba(8'h01, 8'h02, 8'h03, 8'h05));
      send_flush();

      // --- size code 0 behaves as red only ---
      settle();
      configure(3'd0, 16'd100);
      send_pixel(rgba(8'hAB, 8'h00, 8'h00, 8'h00));
      send_pixel(rgba(8'hAB, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(rgba(8'hAC, 8'h00, 8'h00, 8'h00));
      send_flush();

      // --- size code 5 behaves as BGRA; literal meets its last pixel ---
      settle();
      configure(3'd5, 16'd100);
      send_pixel(rgba(8'h11, 8'h22, 8'h33, 8'h44));
      send_pixel(rgba(8'h11, 8'h22, 8'h33, 8'h45));
      send_pixel(rgba(8'h11, 8'h22, 8'h33, 8'h45));
      send_flush();

      // --- random phases, sizes and line widths, all idling modes ---
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         pb = (phase < 4) ? 3'(phase + 1) : 3'($urandom_range(7));
         case (phase)
            1:       lw = 16'hFFFF;
            2:       lw = 16'd0;
            5:       lw = 16'($urandom_range(1, 3));  // likely below the current column
            default: lw = line_col + 16'($urandom_range(1, 6));
         endcase
         configure(pb, lw);
         set_idling(phase % 4);
         random_phase(PHASE_ITEMS);
      end

      settle();
      if (fail_count == 0 && words_due == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
